### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the duty pipeline checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is ignored while reset is asserted
`define SVPWM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define SVPWM_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared widths, register codes, types and arithmetic helpers
// ----------------------------------------------------------------------------
package svpwm_pkg;

	// field and bus widths
	localparam int unsigned VOLT_W      = 16;
	localparam int unsigned PERIOD_W    = 14;
	localparam int unsigned SQRT3_W     = 15;
	localparam int unsigned DUTY_W      = 14;
	localparam int unsigned CALC_W      = 36;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 48;
	localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 3 * DUTY_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SQRT3  = 2'd1;

	// register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 14'd4000;
	localparam logic [SQRT3_W-1:0]  SQRT3_RST  = 15'd6927;

	// scaling shifts: divide by 262144 and by 131072
	localparam int unsigned HALF_SHIFT = 18;
	localparam int unsigned FULL_SHIFT = 17;

	localparam int DUTY_MAX = (2 ** DUTY_W) - 1;

	typedef logic signed [CALC_W-1:0] calc_t;
	typedef logic [DUTY_W-1:0] duty_t;

	// per-stage load strobes of the datapath pipeline
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} pipe_ld_t;

	// which pair of terms drives the sector formula
	typedef enum logic [1:0] {
		MODE_YZ = 2'd0,
		MODE_XZ = 2'd1,
		MODE_YX = 2'd2
	} sector_mode_t;

	// signed divide by 2**sh, truncating toward zero
	function automatic calc_t div_pow2(input calc_t v, input int unsigned sh);
		calc_t bias;
		bias = v[CALC_W-1] ? calc_t'((calc_t'(1) <<< sh) - calc_t'(1)) : '0;
		return (v + bias) >>> sh;
	endfunction

	// clamp to the compare register range
	function automatic duty_t clamp_duty(input calc_t v);
		duty_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > calc_t'(DUTY_MAX)) begin
			r = '1;
		end else begin
			r = v[DUTY_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/svpwm_three_phase_duty_top.sv
// ----------------------------------------------------------------------------
// svpwm_three_phase_duty_top
// space vector pwm duty calculation, streaming in and out
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one voltage vector per transaction (alpha, beta), m_* one set
//   of three timer compare values per transaction. cfg_* writes the period
//   (index 0) and the sqrt3-scaled period (index 1); cfg_ready is always high
//   and writes belong in idle time, with nothing in flight.
//   Path: an accepted vector passes the input register, the product
//   register, the x/y/z register and then the output register, which
//   drives m_tvalid.
//   Throughput: one vector per cycle while m_tready stays high, set by the
//   four-register pipeline, each stage refilling in the cycle it drains.
//   Reset clears all stage valid flags and loads the register defaults
//   (period 4000, sqrt3 period 6927); the block is ready right away.
//   A stalled receiver holds the result on m_tdata; the stages behind it
//   keep filling, and s_tready falls only once all of them hold a vector.
// ----------------------------------------------------------------------------
module svpwm_three_phase_duty_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// s_tdata: alpha_voltage [15:0], beta_voltage [31:16]
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [svpwm_pkg::IN_TDATA_W-1:0]      s_tdata,
	// m_tdata: duty_a [13:0], duty_b [27:14], duty_c [41:28], zero [47:42]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [svpwm_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [svpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [svpwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [svpwm_pkg::PERIOD_W-1:0] period_q;
	logic [svpwm_pkg::SQRT3_W-1:0]  sqrt3_q;
	svpwm_pkg::pipe_ld_t            ld;
	svpwm_pkg::calc_t               x_s3;
	svpwm_pkg::calc_t               y_s3;
	svpwm_pkg::calc_t               z_s3;
	svpwm_pkg::duty_t               duty_a;
	svpwm_pkg::duty_t               duty_b;
	svpwm_pkg::duty_t               duty_c;
	logic                           v_s1;
	logic                           v_s2;
	logic                           v_s3;
	logic                           out_valid_q;
	logic [svpwm_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic                           rdy_out;
	logic                           rdy_s3;
	logic                           rdy_s2;
	logic                           rdy_s1;
	logic                           ld_out;

	// configuration registers
	svpwm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.period_q  (period_q),
		.sqrt3_q   (sqrt3_q)
	);

	// per-stage ready: a stage takes new data when empty or draining
	assign rdy_out = !out_valid_q || m_tready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign ld.ld_s1 = s_tvalid && rdy_s1;
	assign ld.ld_s2 = v_s1 && rdy_s2;
	assign ld.ld_s3 = v_s2 && rdy_s3;
	assign ld_out   = v_s3 && rdy_out;

	assign s_tready = rdy_s1;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= ld.ld_s1 || (v_s1 && !ld.ld_s2);
			v_s2        <= ld.ld_s2 || (v_s2 && !ld.ld_s3);
			v_s3        <= ld.ld_s3 || (v_s3 && !ld_out);
			out_valid_q <= ld_out || (out_valid_q && !m_tready);
		end
	end

	// products and x/y/z terms
	svpwm_prod u_prod (
		.clk           (clk),
		.ld            (ld),
		.alpha_voltage ($signed(s_tdata[15:0])),
		.beta_voltage  ($signed(s_tdata[31:16])),
		.period_cycles (period_q),
		.sqrt3_period  (sqrt3_q),
		.x_s3          (x_s3),
		.y_s3          (y_s3),
		.z_s3          (z_s3)
	);

	// sector formulas and clamp
	svpwm_sector u_sector (
		.x             (x_s3),
		.y             (y_s3),
		.z             (z_s3),
		.period_cycles (period_q),
		.duty_a        (duty_a),
		.duty_b        (duty_b),
		.duty_c        (duty_c)
	);

	// output register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_data_q <= {{svpwm_pkg::OUT_PAD_W{1'b0}}, duty_c, duty_b, duty_a};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### rtl/svpwm_cfg_regs.sv
// ----------------------------------------------------------------------------
// svpwm_cfg_regs
// period and sqrt3-scaled period registers behind the config write channel
// ----------------------------------------------------------------------------
module svpwm_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [svpwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [svpwm_pkg::PERIOD_W-1:0]      period_q,
	output logic [svpwm_pkg::SQRT3_W-1:0]       sqrt3_q
);

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= svpwm_pkg::PERIOD_RST;
			sqrt3_q  <= svpwm_pkg::SQRT3_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				svpwm_pkg::REG_PERIOD: period_q <= cfg_data[svpwm_pkg::PERIOD_W-1:0];
				svpwm_pkg::REG_SQRT3:  sqrt3_q  <= cfg_data[svpwm_pkg::SQRT3_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/svpwm_prod.sv
// ----------------------------------------------------------------------------
// svpwm_prod
// input register, voltage products and the X/Y/Z terms, one stage each
// ----------------------------------------------------------------------------
module svpwm_prod (
	input  logic                                   clk,
	input  svpwm_pkg::pipe_ld_t                    ld,
	input  logic signed [svpwm_pkg::VOLT_W-1:0]    alpha_voltage,
	input  logic signed [svpwm_pkg::VOLT_W-1:0]    beta_voltage,
	input  logic [svpwm_pkg::PERIOD_W-1:0]         period_cycles,
	input  logic [svpwm_pkg::SQRT3_W-1:0]          sqrt3_period,
	output svpwm_pkg::calc_t                       x_s3,
	output svpwm_pkg::calc_t                       y_s3,
	output svpwm_pkg::calc_t                       z_s3
);

	localparam int unsigned UA_W = svpwm_pkg::VOLT_W + svpwm_pkg::SQRT3_W + 1;
	localparam int unsigned BP_W = svpwm_pkg::VOLT_W + svpwm_pkg::PERIOD_W + 1;

	logic signed [svpwm_pkg::VOLT_W-1:0] alpha_s1;
	logic signed [svpwm_pkg::VOLT_W-1:0] beta_s1;
	logic signed [UA_W-1:0]              ua_c;
	logic signed [BP_W-1:0]              bp_c;
	logic signed [UA_W-1:0]              ua_s2;
	logic signed [BP_W-1:0]              bp_s2;
	svpwm_pkg::calc_t                    x_c;
	svpwm_pkg::calc_t                    ua_e;
	svpwm_pkg::calc_t                    y_c;
	svpwm_pkg::calc_t                    z_c;

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (ld.ld_s1) begin
			alpha_s1 <= alpha_voltage;
			beta_s1  <= beta_voltage;
		end
	end

	// stage 2: alpha*sqrt3_period and beta*period
	assign ua_c = alpha_s1 * $signed({1'b0, sqrt3_period});
	assign bp_c = beta_s1 * $signed({1'b0, period_cycles});

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			ua_s2 <= ua_c;
			bp_s2 <= bp_c;
		end
	end

	// stage 3: x = -2*beta*period, y and z halved toward zero
	assign x_c  = -(svpwm_pkg::calc_t'(bp_s2) <<< 1);
	assign ua_e = svpwm_pkg::calc_t'(ua_s2);
	assign y_c  = svpwm_pkg::div_pow2(x_c + ua_e, 1);
	assign z_c  = svpwm_pkg::div_pow2(x_c - ua_e, 1);

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			x_s3 <= x_c;
			y_s3 <= y_c;
			z_s3 <= z_c;
		end
	end

endmodule

### rtl/svpwm_sector.sv
// ----------------------------------------------------------------------------
// svpwm_sector
// sector pick from the signs of x, y, z and the three clamped duties
// ----------------------------------------------------------------------------
module svpwm_sector (
	input  svpwm_pkg::calc_t                 x,
	input  svpwm_pkg::calc_t                 y,
	input  svpwm_pkg::calc_t                 z,
	input  logic [svpwm_pkg::PERIOD_W-1:0]   period_cycles,
	output svpwm_pkg::duty_t                 duty_a,
	output svpwm_pkg::duty_t                 duty_b,
	output svpwm_pkg::duty_t                 duty_c
);

	svpwm_pkg::sector_mode_t mode;
	svpwm_pkg::calc_t        quarter;
	svpwm_pkg::calc_t        qx;
	svpwm_pkg::calc_t        qy;
	svpwm_pkg::calc_t        qz;
	svpwm_pkg::calc_t        diff;
	svpwm_pkg::calc_t        ta;
	svpwm_pkg::calc_t        tb;
	svpwm_pkg::calc_t        tc;
	logic                    y_neg;
	logic                    z_neg;
	logic                    x_pos;

	assign quarter = svpwm_pkg::calc_t'(period_cycles[svpwm_pkg::PERIOD_W-1:2]);
	assign qx      = svpwm_pkg::div_pow2(x, svpwm_pkg::FULL_SHIFT);
	assign qy      = svpwm_pkg::div_pow2(y, svpwm_pkg::FULL_SHIFT);
	assign qz      = svpwm_pkg::div_pow2(z, svpwm_pkg::FULL_SHIFT);
	assign y_neg   = y[svpwm_pkg::CALC_W-1];
	assign z_neg   = z[svpwm_pkg::CALC_W-1];
	assign x_pos   = (x > 0);

	// sector decode
	always_comb begin
		if (y_neg) begin
			if (z_neg) begin
				mode = svpwm_pkg::MODE_YZ;
			end else if (!x_pos) begin
				mode = svpwm_pkg::MODE_XZ;
			end else begin
				mode = svpwm_pkg::MODE_YX;
			end
		end else begin
			if (!z_neg) begin
				mode = svpwm_pkg::MODE_YZ;
			end else if (!x_pos) begin
				mode = svpwm_pkg::MODE_YX;
			end else begin
				mode = svpwm_pkg::MODE_XZ;
			end
		end
	end

	// sector formulas
	always_comb begin
		case (mode)
			svpwm_pkg::MODE_YZ: diff = y - z;
			svpwm_pkg::MODE_XZ: diff = x - z;
			svpwm_pkg::MODE_YX: diff = y - x;
			default:            diff = y - z;
		endcase
		ta = quarter + svpwm_pkg::div_pow2(diff, svpwm_pkg::HALF_SHIFT);
		case (mode)
			svpwm_pkg::MODE_XZ: begin
				tb = ta + qz;
				tc = tb - qx;
			end
			svpwm_pkg::MODE_YX: begin
				tc = ta - qy;
				tb = tc + qx;
			end
			default: begin
				tb = ta + qz;
				tc = ta - qy;
			end
		endcase
	end

	assign duty_a = svpwm_pkg::clamp_duty(ta);
	assign duty_b = svpwm_pkg::clamp_duty(tb);
	assign duty_c = svpwm_pkg::clamp_duty(tc);

endmodule

### rtl/svpwm_checker.sv
// ----------------------------------------------------------------------------
// svpwm_checker
// port-level checks on the duty pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svpwm_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tready,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [svpwm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	// no result is shown while reset is held
	`SVPWM_ASSERT_NR(a_reset_clears_out, clk, !arst_n |-> !m_tvalid, "m_tvalid high in reset")

	// input backpressure only comes from a full pipeline behind a stalled output
	`SVPWM_ASSERT(a_stall_source, clk, arst_n, !s_tready |-> (m_tvalid && !m_tready), "s_tready low without output stall")

	// a stalled result holds its value
	`SVPWM_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

	// pad bits above the three duties stay zero
	`SVPWM_ASSERT(a_out_pad, clk, arst_n, m_tvalid |-> (m_tdata[47:42] == 6'd0), "nonzero pad bits in m_tdata")

endmodule

bind svpwm_three_phase_duty_top svpwm_checker u_svpwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the space vector pwm duty calculation block
// ----------------------------------------------------------------------------
// A short table of voltage vectors runs under the reset register values.
// Random vectors follow under a series of register settings: the low and high
// ends of the ranges, matched period pairs, masked and out-of-range words, and
// writes to the unused indexes. Every accepted vector without a table expectation
// is run through a local duty predictor. Each result transaction is compared
// field by field with the oldest pending prediction. Both stream sides idle in
// random bursts, except in the last phase, which runs at full rate.
// ----------------------------------------------------------------------------
module tb;
	import svpwm_pkg::*;

	localparam int CLK_PERIOD_NS = 4;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam longint TIMEOUT_NS = 2_000_000;
	localparam longint SCALE_HALF = 262144;
	localparam longint SCALE_FULL = 131072;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		duty_t a;
		duty_t b;
		duty_t c;
	} duty_set_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0] alpha;
		logic signed [VOLT_W-1:0] beta;
		logic                     typed;
		duty_set_t                want;
	} vector_row_t;

	typedef enum logic [1:0] {
		LOAD_NONE,
		LOAD_FIXED,
		LOAD_MATCHED,
		LOAD_ANY
	} load_kind_t;

	typedef struct packed {
		load_kind_t           kind;
		logic [CFG_DATA_W-1:0] period_word;
		logic [CFG_DATA_W-1:0] sqrt3_word;
		int unsigned          vectors;
	} phase_t;

	typedef enum logic [1:0] {
		SHAPE_FULL,
		SHAPE_SMALL,
		SHAPE_EDGE,
		SHAPE_AXIS
	} vector_shape_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// register copies for prediction
	logic [PERIOD_W-1:0] period_shadow = PERIOD_RST;
	logic [SQRT3_W-1:0] sqrt3_shadow = SQRT3_RST;

	duty_set_t pending_duties [$];
	int unsigned fail_count = 0;
	bit gaps_on = 1'b1;

	// directed vectors, run under the reset register values
	vector_row_t directed_rows [23] = '{
		'{16'sd0, 16'sd0, 1'b1, '{14'd1000, 14'd1000, 14'd1000}},
		'{16'sd0, -16'sd32768, 1'b1, '{14'd1000, 14'd2000, 14'd0}},
		'{16'sd0, 16'sd32767, 1'b1, '{14'd1000, 14'd1, 14'd1999}},
		'{16'sd32767, 16'sd0, 1'b0, '0},
		'{-16'sd32768, 16'sd0, 1'b0, '0},
		'{16'sd32767, 16'sd32767, 1'b0, '0},
		'{-16'sd32768, -16'sd32768, 1'b0, '0},
		'{16'sd32767, -16'sd32768, 1'b0, '0},
		'{-16'sd32768, 16'sd32767, 1'b0, '0},
		'{16'sd1, 16'sd0, 1'b0, '0},
		'{-16'sd1, 16'sd0, 1'b0, '0},
		'{16'sd0, 16'sd1, 1'b0, '0},
		'{16'sd0, -16'sd1, 1'b0, '0},
		'{-16'sd1, -16'sd1, 1'b0, '0},
		'{16'sd16000, 16'sd4000, 1'b0, '0},
		'{16'sd4000, 16'sd16000, 1'b0, '0},
		'{-16'sd4000, 16'sd16000, 1'b0, '0},
		'{-16'sd16000, 16'sd4000, 1'b0, '0},
		'{-16'sd16000, -16'sd4000, 1'b0, '0},
		'{-16'sd4000, -16'sd16000, 1'b0, '0},
		'{16'sd4000, -16'sd16000, 1'b0, '0},
		'{16'sd16000, -16'sd4000, 1'b0, '0},
		'{16'sd30000, 16'sd30000, 1'b0, '0}
	};

	// register settings, one per phase; the last phase has no idling
	phase_t phases [10] = '{
		'{LOAD_NONE, 16'd0, 16'd0, 150},
		'{LOAD_FIXED, 16'd2, 16'd3, 150},
		'{LOAD_FIXED, 16'd16383, 16'd28375, 200},
		'{LOAD_MATCHED, 16'd0, 16'd0, 200},
		'{LOAD_FIXED, 16'hFFFF, 16'hFFFF, 150},
		'{LOAD_MATCHED, 16'd0, 16'd0, 200},
		'{LOAD_FIXED, 16'hC000, 16'h8000, 60},
		'{LOAD_MATCHED, 16'd0, 16'd0, 200},
		'{LOAD_ANY, 16'd0, 16'd0, 150},
		'{LOAD_FIXED, 16'd1000, 16'd1732, 290}
	};

	svpwm_three_phase_duty_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD_NS / 2) clk = ~clk;

	// lower clamp at zero, saturate above the compare range
	function automatic duty_t to_compare(input longint v);
		duty_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > longint'(DUTY_MAX)) begin
			r = duty_t'(DUTY_MAX);
		end else begin
			r = duty_t'(v);
		end
		return r;
	endfunction

	// compare values for one voltage vector under the current registers
	function automatic duty_set_t predict_duties(input logic signed [VOLT_W-1:0] alpha,
			input logic signed [VOLT_W-1:0] beta);
		longint ua;
		longint x;
		longint y;
		longint z;
		longint quarter;
		longint ta;
		longint tb;
		longint tc;
		duty_set_t r;
		ua = longint'(alpha) * longint'(sqrt3_shadow);
		x = -(longint'(beta) * longint'(period_shadow)) * 2;
		y = (x + ua) / 2;
		z = (x - ua) / 2;
		quarter = longint'(period_shadow) / 4;
		// sector choice from the signs of y, z and x
		if ((y < 0 && z < 0) || (y >= 0 && z >= 0)) begin
			ta = quarter + (y - z) / SCALE_HALF;
			tb = ta + z / SCALE_FULL;
			tc = ta - y / SCALE_FULL;
		end else if ((y < 0 && x <= 0) || (y >= 0 && x > 0)) begin
			ta = quarter + (x - z) / SCALE_HALF;
			tb = ta + z / SCALE_FULL;
			tc = tb - x / SCALE_FULL;
		end else begin
			ta = quarter + (y - x) / SCALE_HALF;
			tc = ta - y / SCALE_FULL;
			tb = tc + x / SCALE_FULL;
		end
		r.a = to_compare(ta);
		r.b = to_compare(tb);
		r.c = to_compare(tc);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		$display("[%0t] mismatch on %0s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// one vector transaction; the prediction is queued at acceptance
	task automatic drive_vector(input logic signed [VOLT_W-1:0] alpha,
			input logic signed [VOLT_W-1:0] beta, input logic typed, input duty_set_t typed_want);
		duty_set_t want;
		want = typed ? typed_want : predict_duties(alpha, beta);
		s_tvalid <= 1'b1;
		s_tdata <= {beta, alpha};
		do @(posedge clk); while (!s_tready);
		pending_duties.push_back(want);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic logic signed [VOLT_W-1:0] random_component(input vector_shape_t shape);
		logic signed [VOLT_W-1:0] v;
		case (shape)
			SHAPE_SMALL: v = VOLT_W'($urandom_range(0, 511)) - 16'sd256;
			SHAPE_EDGE: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sd0;
					3: v = 16'sd1;
					default: v = -16'sd1;
				endcase
			end
			default: v = VOLT_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic drive_random_vector();
		vector_shape_t shape;
		logic signed [VOLT_W-1:0] alpha;
		logic signed [VOLT_W-1:0] beta;
		case ($urandom_range(0, 9))
			0, 1: shape = SHAPE_SMALL;
			2: shape = SHAPE_EDGE;
			3: shape = SHAPE_AXIS;
			default: shape = SHAPE_FULL;
		endcase
		alpha = random_component(shape == SHAPE_AXIS ? SHAPE_FULL : shape);
		beta = random_component(shape == SHAPE_AXIS ? SHAPE_FULL : shape);
		// sector borders: one axis at zero
		if (shape == SHAPE_AXIS) begin
			if ($urandom_range(0, 1) == 0) begin
				alpha = '0;
			end else begin
				beta = '0;
			end
		end
		drive_vector(alpha, beta, 1'b0, '0);
	endtask

	// config transaction; the caller lowers cfg_valid after the last one
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PERIOD: period_shadow = word[PERIOD_W-1:0];
			REG_SQRT3: sqrt3_shadow = word[SQRT3_W-1:0];
			default: ;
		endcase
	endtask

	// hold the sender until every pending result is back, then let the pipe settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_duties.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver backpressure in random bursts
	initial begin
		m_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (gaps_on && m_tready && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		duty_set_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_duties.size() == 0) begin
				report_mismatch("result count, no vector pending", 1, 0);
			end else begin
				want = pending_duties.pop_front();
				if (m_tdata[DUTY_W-1:0] !== want.a)
					report_mismatch("duty_a", m_tdata[DUTY_W-1:0], want.a);
				if (m_tdata[2*DUTY_W-1:DUTY_W] !== want.b)
					report_mismatch("duty_b", m_tdata[2*DUTY_W-1:DUTY_W], want.b);
				if (m_tdata[3*DUTY_W-1:2*DUTY_W] !== want.c)
					report_mismatch("duty_c", m_tdata[3*DUTY_W-1:2*DUTY_W], want.c);
				if (m_tdata[OUT_TDATA_W-1:3*DUTY_W] !== '0)
					report_mismatch("tdata pad", m_tdata[OUT_TDATA_W-1:3*DUTY_W], 0);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [PERIOD_W-1:0] matched_period;
		logic [CFG_DATA_W-1:0] period_word;
		logic [CFG_DATA_W-1:0] sqrt3_word;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_vector(directed_rows[i].alpha, directed_rows[i].beta, directed_rows[i].typed,
				directed_rows[i].want);

		foreach (phases[p]) begin
			wait_drained();
			period_word = phases[p].period_word;
			sqrt3_word = phases[p].sqrt3_word;
			if (phases[p].kind == LOAD_MATCHED) begin
				matched_period = PERIOD_W'($urandom_range(2, 16383));
				period_word = CFG_DATA_W'(matched_period);
				sqrt3_word = CFG_DATA_W'((int'(matched_period) * 28377) / 16384);
			end else if (phases[p].kind == LOAD_ANY) begin
				period_word = CFG_DATA_W'($urandom);
				sqrt3_word = CFG_DATA_W'($urandom);
			end
			// spare index writes in between must leave both registers alone
			if (phases[p].kind != LOAD_NONE) begin
				write_register(REG_PERIOD, period_word);
				write_register(p % 2 == 0 ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
				write_register(REG_SQRT3, sqrt3_word);
				cfg_valid <= 1'b0;
			end
			if (p == $size(phases) - 1)
				gaps_on = 1'b0;
			repeat (phases[p].vectors) drive_random_vector();
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
